FILE: rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

    // store geometry
    localparam int DEPTH   = 16;
    // PRIO_W and TAG_W may not exceed FIELD_W: the ports carry 16 bits
    localparam int PRIO_W  = 16;
    localparam int TAG_W   = 16;
    localparam int FIELD_W = 16;
    localparam int POS_W   = 5;

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int POSX_W = ((IDX_W + 1) > POS_W) ? (IDX_W + 1) : POS_W;

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_POP     = 2'd1,
        KIND_DELETE  = 2'd2,
        KIND_READOUT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_DUP      = 3'd2,
        ST_BADPRIO  = 3'd3,
        ST_FULL     = 3'd4,
        ST_NOTFOUND = 3'd5
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic latch;    // capture the incoming item
        logic exec;     // run the captured command, load the result register
        logic advance;  // readout: load the next entry into the result register
    } spq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_last; // result register holds the final result of its item
    } spq_stat_t;

endpackage

`default_nettype wire

FILE: rtl/spq_ctrl.sv
`default_nettype none

module spq_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  spq_pkg::spq_stat_t    stat,
    output spq_pkg::spq_cmd_t     cmd
);
    import spq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SEND = 4'b0100,
        S_HOLD = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_SEND;
            end
            S_SEND: begin
                m_valid = 1'b1;
                s_ready = stat.out_last;
                if (m_ready && !stat.out_last) begin
                    cmd.advance = 1'b1;
                end else if (m_ready) begin
                    if (s_valid) begin
                        cmd.latch  = 1'b1;
                        state_next = S_EXEC;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else if (s_valid && stat.out_last) begin
                    cmd.latch  = 1'b1;
                    state_next = S_HOLD;
                end
            end
            S_HOLD: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_EXEC;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/spq_datapath.sv
`default_nettype none

module spq_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  spq_pkg::spq_cmd_t                  cmd,
    output spq_pkg::spq_stat_t                 stat,
    input  wire logic [1:0]                    s_kind,
    input  wire logic [spq_pkg::FIELD_W-1:0]   s_new_priority,
    input  wire logic [spq_pkg::FIELD_W-1:0]   s_new_tag,
    input  wire logic [spq_pkg::POS_W-1:0]     s_target_position,
    output logic [2:0]                         m_status,
    output logic [spq_pkg::FIELD_W-1:0]        m_out_priority,
    output logic [spq_pkg::FIELD_W-1:0]        m_out_tag,
    output logic [spq_pkg::POS_W-1:0]          m_out_position,
    output logic                               m_last
);
    import spq_pkg::*;

    // captured command
    kind_t              kind_reg;
    logic [PRIO_W-1:0]  nprio_reg;
    logic [TAG_W-1:0]   ntag_reg;
    logic [POS_W-1:0]   tpos_reg;

    // sorted entry array, head at index 0
    logic [PRIO_W-1:0]  prio_reg  [DEPTH];
    logic [PRIO_W-1:0]  prio_next [DEPTH];
    logic [TAG_W-1:0]   tag_reg   [DEPTH];
    logic [TAG_W-1:0]   tag_next  [DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // read pointer
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   rd_idx_next;
    logic [IDX_W-1:0]   del_idx;
    logic [PRIO_W-1:0]  rd_prio;
    logic [TAG_W-1:0]   rd_tag;
    logic [POSX_W-1:0]  rd_pos;
    logic               rd_last;

    // result register
    status_t            status_reg;
    logic [PRIO_W-1:0]  oprio_reg;
    logic [TAG_W-1:0]   otag_reg;
    logic [POS_W-1:0]   opos_reg;
    logic               last_reg;

    logic [DEPTH-1:0]   gt;
    logic [DEPTH-1:0]   eq;
    logic [CMP_W-1:0]   tpos_ext;
    logic [CMP_W-1:0]   cnt_ext;

    status_t            res_status;
    logic               res_show;
    logic               res_last;
    logic               do_insert;
    logic               do_remove;

    // parallel compare against every occupied entry
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            gt[i] = (CNT_W'(i) < count_reg) && (prio_reg[i] > nprio_reg);
            eq[i] = (CNT_W'(i) < count_reg) && (prio_reg[i] == nprio_reg);
        end
    end

    assign tpos_ext = CMP_W'(tpos_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign del_idx  = (kind_reg == KIND_POP) ? '0 : IDX_W'(tpos_ext - CMP_W'(1));

    always_comb begin
        if (cmd.exec) begin
            rd_idx_next = (kind_reg == KIND_READOUT) ? '0 : del_idx;
        end else begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        end
    end

    assign rd_prio = prio_reg[rd_idx_next];
    assign rd_tag  = tag_reg[rd_idx_next];
    assign rd_pos  = POSX_W'(rd_idx_next) + POSX_W'(1);
    assign rd_last = (CNT_W'(rd_idx_next) + CNT_W'(1)) == count_reg;

    // command decode
    always_comb begin
        res_status = ST_OK;
        res_show   = 1'b0;
        res_last   = 1'b1;
        do_insert  = 1'b0;
        do_remove  = 1'b0;
        unique case (kind_reg)
            KIND_INSERT: begin
                if (nprio_reg == '0) begin
                    res_status = ST_BADPRIO;
                end else if (|eq) begin
                    res_status = ST_DUP;
                end else if (count_reg == CNT_W'(DEPTH)) begin
                    res_status = ST_FULL;
                end else begin
                    do_insert = 1'b1;
                end
            end
            KIND_POP: begin
                if (count_reg == '0) begin
                    res_status = ST_EMPTY;
                end else begin
                    res_show  = 1'b1;
                    do_remove = 1'b1;
                end
            end
            KIND_DELETE: begin
                if (count_reg == '0) begin
                    res_status = ST_EMPTY;
                end else if (tpos_ext == '0 || tpos_ext > cnt_ext) begin
                    res_status = ST_NOTFOUND;
                end else begin
                    res_show  = 1'b1;
                    do_remove = 1'b1;
                end
            end
            KIND_READOUT: begin
                if (count_reg == '0) begin
                    res_status = ST_EMPTY;
                end else begin
                    res_show = 1'b1;
                    res_last = rd_last;
                end
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    // shift network: open a slot on insert, close one on removal
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            prio_next[i] = prio_reg[i];
            tag_next[i]  = tag_reg[i];
        end
        count_next = count_reg;
        if (cmd.exec && do_insert) begin
            if (!gt[0]) begin
                prio_next[0] = nprio_reg;
                tag_next[0]  = ntag_reg;
            end
            for (int i = 1; i < DEPTH; i++) begin
                if (!gt[i]) begin
                    if (gt[i-1]) begin
                        prio_next[i] = nprio_reg;
                        tag_next[i]  = ntag_reg;
                    end else begin
                        prio_next[i] = prio_reg[i-1];
                        tag_next[i]  = tag_reg[i-1];
                    end
                end
            end
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.exec && do_remove) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                if (IDX_W'(i) >= del_idx) begin
                    prio_next[i] = prio_reg[i+1];
                    tag_next[i]  = tag_reg[i+1];
                end
            end
            count_next = count_reg - CNT_W'(1);
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            kind_reg  <= kind_t'(s_kind);
            nprio_reg <= s_new_priority[PRIO_W-1:0];
            ntag_reg  <= s_new_tag[TAG_W-1:0];
            tpos_reg  <= s_target_position;
        end
        for (int i = 0; i < DEPTH; i++) begin
            prio_reg[i] <= prio_next[i];
            tag_reg[i]  <= tag_next[i];
        end
        if (cmd.exec || cmd.advance) begin
            rd_idx_reg <= rd_idx_next;
            oprio_reg  <= '0;
            otag_reg   <= '0;
            opos_reg   <= '0;
            if (cmd.advance || res_show) begin
                oprio_reg <= rd_prio;
                otag_reg  <= rd_tag;
                opos_reg  <= rd_pos[POS_W-1:0];
            end
        end
        if (cmd.exec) begin
            status_reg <= res_status;
        end else if (cmd.advance) begin
            status_reg <= ST_OK;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            last_reg  <= 1'b1;
        end else begin
            count_reg <= count_next;
            if (cmd.exec) begin
                last_reg <= res_last;
            end else if (cmd.advance) begin
                last_reg <= rd_last;
            end
        end
    end

    assign stat.out_last  = last_reg;
    assign m_status       = status_reg;
    assign m_out_priority = FIELD_W'(oprio_reg);
    assign m_out_tag      = FIELD_W'(otag_reg);
    assign m_out_position = opos_reg;
    assign m_last         = last_reg;

endmodule

`default_nettype wire

FILE: rtl/sorted_priority_queue.sv
`default_nettype none

// channel  dir  handshake          payload
// -------  ---  -----------------  ---------------------------------------------------
// s_       in   s_valid / s_ready  s_kind, s_new_priority, s_new_tag, s_target_position
// m_       out  m_valid / m_ready  m_status, m_out_priority, m_out_tag, m_out_position,
//                                  m_last
//
// insert, pop and delete pass through an execute state, in which the parallel
// compare and shift network rewrites the entry array, then a state in the result
// register, during which the next item is already taken. readout then presents
// each entry in turn after the execute state, advancing on every accepted result.
// aresetn (synchronous) empties the store; entry contents are not cleared.
// a stalled result holds, and at most one further item is captured behind it.

module sorted_priority_queue (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // command channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_kind,
    input  wire logic [spq_pkg::FIELD_W-1:0]   s_new_priority,
    input  wire logic [spq_pkg::FIELD_W-1:0]   s_new_tag,
    input  wire logic [spq_pkg::POS_W-1:0]     s_target_position,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [2:0]                         m_status,
    output logic [spq_pkg::FIELD_W-1:0]        m_out_priority,
    output logic [spq_pkg::FIELD_W-1:0]        m_out_tag,
    output logic [spq_pkg::POS_W-1:0]          m_out_position,
    output logic                               m_last
);
    import spq_pkg::*;

    // command and status between controller and datapath
    spq_cmd_t  cmd;
    spq_stat_t stat;

    // sequencer: capture, execute, present result, step through readout
    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // entry array, compare and shift network, result register
    spq_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_kind            (s_kind),
        .s_new_priority    (s_new_priority),
        .s_new_tag         (s_new_tag),
        .s_target_position (s_target_position),
        .m_status          (m_status),
        .m_out_priority    (m_out_priority),
        .m_out_tag         (m_out_tag),
        .m_out_position    (m_out_position),
        .m_last            (m_last)
    );

endmodule

`default_nettype wire
